// ----- sv/assert_macros.svh -----
// Assertion macros shared by the lexer RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define SFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SFL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sfl_pkg.sv -----
// Shared types, character codes and classification functions for the STEP file lexer.
// No dependencies.
package sfl_pkg;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_IDENT  = 4'd1,
    M_INT    = 4'd2,
    M_FRAC   = 4'd3,
    M_EXP0   = 4'd4,
    M_EXPSGN = 4'd5,
    M_EXPDIG = 4'd6,
    M_TAIL   = 4'd7,
    M_SIGN   = 4'd8,
    M_ID     = 4'd9,
    M_SQ     = 4'd10,
    M_SQHOLD = 4'd11,
    M_DQ     = 4'd12,
    M_OTHER  = 4'd13
  } mode_t;

  localparam logic [2:0] T_END   = 3'd0;
  localparam logic [2:0] T_TEXT  = 3'd1;
  localparam logic [2:0] T_INT   = 3'd2;
  localparam logic [2:0] T_REAL  = 3'd3;
  localparam logic [2:0] T_ID    = 3'd4;
  localparam logic [2:0] T_PUNCT = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_USC   = 8'h5F;
  localparam logic [7:0] CH_LE    = 8'h65;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       tend;
    logic [2:0] ttype;
    logic       last;
  } rec_t;

  typedef struct packed {
    logic  emit;
    rec_t  rec;
    mode_t mode;
    logic  clr_real;
  } start_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
           ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
  endfunction

  function automatic rec_t mk_rec(input logic [7:0] data, input logic valid,
                                  input logic tend, input logic [2:0] ttype);
    rec_t r;
    r.data  = data;
    r.valid = valid;
    r.tend  = tend;
    r.ttype = ttype;
    r.last  = 1'b0;
    return r;
  endfunction

  // Classify a byte that opens a new token.
  function automatic start_t start_fn(input logic [7:0] c);
    start_t s;
    s.emit     = 1'b1;
    s.rec      = mk_rec(c, 1'b1, 1'b0, T_END);
    s.mode     = M_IDLE;
    s.clr_real = 1'b0;
    if ((c == CH_SP) || (c == CH_NL)) begin
      s.emit = 1'b0;
    end else if (c == CH_NUL) begin
      s.rec = mk_rec(CH_NUL, 1'b0, 1'b1, T_END);
    end else if (is_alpha(c) || (c == CH_USC)) begin
      s.mode = M_IDENT;
    end else if (is_digit(c)) begin
      s.mode     = M_INT;
      s.clr_real = 1'b1;
    end else if (c == CH_SQ) begin
      s.mode = M_SQ;
    end else if (c == CH_DQ) begin
      s.mode = M_DQ;
    end else if (c == CH_HASH) begin
      s.mode = M_ID;
    end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      s.mode = M_SIGN;
    end else if (is_punct(c)) begin
      s.rec = mk_rec(c, 1'b1, 1'b1, T_PUNCT);
    end else begin
      s.mode = M_OTHER;
    end
    return s;
  endfunction

endpackage

// ----- sv/sfl_step.sv -----
// Next-state and record logic of the lexer for one text byte.
// Depends on sfl_pkg.
module sfl_step (
  input  logic [7:0]     c,
  input  sfl_pkg::mode_t mode,
  input  logic           real_seen,
  output sfl_pkg::mode_t mode_next,
  output logic           real_next,
  output sfl_pkg::step_t stp
);

  sfl_pkg::start_t st;
  sfl_pkg::rec_t   lead;
  logic            lead_en;
  logic            do_start;
  logic [2:0]      num_type;

  assign st       = sfl_pkg::start_fn(c);
  assign num_type = real_seen ? sfl_pkg::T_REAL : sfl_pkg::T_INT;

  always_comb begin
    lead_en   = 1'b0;
    lead      = sfl_pkg::mk_rec(c, 1'b1, 1'b0, sfl_pkg::T_END);
    do_start  = 1'b0;
    mode_next = mode;
    real_next = real_seen;
    case (mode)
      sfl_pkg::M_IDENT: begin
        lead_en = 1'b1;
        if (!(sfl_pkg::is_alnum(c) || (c == sfl_pkg::CH_USC))) begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, sfl_pkg::T_TEXT);
          do_start = 1'b1;
        end
      end
      sfl_pkg::M_INT, sfl_pkg::M_FRAC: begin
        lead_en = 1'b1;
        if (sfl_pkg::is_digit(c)) begin
        end else if ((c == sfl_pkg::CH_DOT) && (mode == sfl_pkg::M_INT)) begin
          real_next = 1'b1;
          mode_next = sfl_pkg::M_FRAC;
        end else if ((c == sfl_pkg::CH_UE) || (c == sfl_pkg::CH_LE)) begin
          real_next = 1'b1;
          mode_next = sfl_pkg::M_EXP0;
        end else if (sfl_pkg::is_alpha(c)) begin
          mode_next = sfl_pkg::M_TAIL;
        end else begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, num_type);
          do_start = 1'b1;
        end
      end
      sfl_pkg::M_EXP0, sfl_pkg::M_EXPSGN: begin
        lead_en = 1'b1;
        if (sfl_pkg::is_digit(c)) begin
          mode_next = sfl_pkg::M_EXPDIG;
        end else if (((c == sfl_pkg::CH_PLUS) || (c == sfl_pkg::CH_MINUS)) &&
                     (mode == sfl_pkg::M_EXP0)) begin
          mode_next = sfl_pkg::M_EXPSGN;
        end else if (c == sfl_pkg::CH_NUL) begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, sfl_pkg::T_TEXT);
          do_start = 1'b1;
        end else begin
          mode_next = sfl_pkg::M_TAIL;
        end
      end
      sfl_pkg::M_EXPDIG: begin
        lead_en = 1'b1;
        if (sfl_pkg::is_digit(c)) begin
        end else if (sfl_pkg::is_alpha(c)) begin
          mode_next = sfl_pkg::M_TAIL;
        end else begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, num_type);
          do_start = 1'b1;
        end
      end
      sfl_pkg::M_TAIL: begin
        lead_en = 1'b1;
        if (!sfl_pkg::is_alnum(c)) begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, sfl_pkg::T_TEXT);
          do_start = 1'b1;
        end
      end
      sfl_pkg::M_SIGN: begin
        lead_en = 1'b1;
        if (sfl_pkg::is_digit(c)) begin
          real_next = 1'b0;
          mode_next = sfl_pkg::M_INT;
        end else begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, sfl_pkg::T_PUNCT);
          do_start = 1'b1;
        end
      end
      sfl_pkg::M_ID: begin
        lead_en = 1'b1;
        if (!sfl_pkg::is_digit(c)) begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, sfl_pkg::T_ID);
          do_start = 1'b1;
        end
      end
      sfl_pkg::M_SQ: begin
        if (c == sfl_pkg::CH_SQ) begin
          mode_next = sfl_pkg::M_SQHOLD;
        end else if (c == sfl_pkg::CH_NUL) begin
          lead_en  = 1'b1;
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, sfl_pkg::T_TEXT);
          do_start = 1'b1;
        end else begin
          lead_en = 1'b1;
        end
      end
      sfl_pkg::M_SQHOLD: begin
        lead_en = 1'b1;
        if (c == sfl_pkg::CH_SQ) begin
          lead      = sfl_pkg::mk_rec(sfl_pkg::CH_SQ, 1'b1, 1'b0, sfl_pkg::T_END);
          mode_next = sfl_pkg::M_SQ;
        end else begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_SQ, 1'b1, 1'b1, sfl_pkg::T_TEXT);
          do_start = 1'b1;
        end
      end
      sfl_pkg::M_DQ: begin
        lead_en = 1'b1;
        if (c == sfl_pkg::CH_DQ) begin
          lead      = sfl_pkg::mk_rec(c, 1'b1, 1'b1, sfl_pkg::T_TEXT);
          mode_next = sfl_pkg::M_IDLE;
        end else if (c == sfl_pkg::CH_NUL) begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, sfl_pkg::T_TEXT);
          do_start = 1'b1;
        end
      end
      sfl_pkg::M_OTHER: begin
        lead_en = 1'b1;
        if ((c == sfl_pkg::CH_NUL) || (c == sfl_pkg::CH_SP)) begin
          lead     = sfl_pkg::mk_rec(sfl_pkg::CH_NUL, 1'b0, 1'b1, sfl_pkg::T_TEXT);
          do_start = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (do_start) begin
      mode_next = st.mode;
      if (st.clr_real) begin
        real_next = 1'b0;
      end
    end

    stp.r0 = '0;
    stp.r1 = '0;
    stp.n  = 2'd0;
    if (lead_en && do_start && st.emit) begin
      stp.r0      = lead;
      stp.r1      = st.rec;
      stp.r1.last = 1'b1;
      stp.n       = 2'd2;
    end else if (lead_en) begin
      stp.r0      = lead;
      stp.r0.last = 1'b1;
      stp.n       = 2'd1;
    end else if (do_start && st.emit) begin
      stp.r0      = st.rec;
      stp.r0.last = 1'b1;
      stp.n       = 2'd1;
    end
  end

endmodule

// ----- sv/sfl_outq.sv -----
// Result record queue: takes up to two records a cycle, delivers one while pop_ready is high.
// Depends on sfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfl_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfl_pkg::step_t stp,
  input  logic           pop_ready,
  output logic           room,
  output logic           nonempty,
  output sfl_pkg::rec_t  head
);

  localparam int PW = $clog2(sfl_pkg::QDEPTH);
  localparam int CW = $clog2(sfl_pkg::QDEPTH + 1);

  sfl_pkg::rec_t q [sfl_pkg::QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    nin;
  logic          pop;

  assign nin        = push ? stp.n : 2'd0;
  assign pop        = pop_ready && nonempty;
  assign nonempty   = (count != '0);
  assign room       = (count <= CW'(sfl_pkg::QDEPTH - 2));
  assign head       = q[rptr];
  assign count_next = count + CW'(nin) - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PW'(nin);
      rptr  <= rptr + PW'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (nin != 2'd0) begin
      q[wptr] <= stp.r0;
    end
    if (nin == 2'd2) begin
      q[wptr + PW'(1)] <= stp.r1;
    end
  end

  `SFL_ASSERT(a_no_overflow, count <= CW'(sfl_pkg::QDEPTH), "record queue overflow")
  `SFL_ASSERT(a_count_track, 1'b1 |=> count == $past(count_next), "queue count mismatch")
  `SFL_ASSERT_ALWAYS(a_reset_empty, rst |=> count == '0, "queue not empty after reset")

endmodule

// ----- sv/step_file_lexer.sv -----
// Streaming STEP file lexer: one text byte per request in, token records out.
// Depends on sfl_pkg, sfl_step, sfl_outq and assert_macros.svh.
//
// A text byte is taken in the cycle it is offered whenever the result queue has room for
// two records, and its records appear from the next cycle on. Each byte yields zero, one or
// two records; the four-entry result queue delivers one record per cycle while out_ready is high,
// so the block sustains one byte per cycle while each byte gives at most one record, and a byte
// that closes one token and opens the next puts two records into the queue.
`include "assert_macros.svh"

module step_file_lexer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] token_byte,
  output logic       byte_valid,
  output logic       token_end,
  output logic [2:0] token_type,
  output logic       last
);

  sfl_pkg::mode_t mode;
  sfl_pkg::mode_t mode_next;
  logic           real_seen;
  logic           real_next;
  sfl_pkg::step_t stp;
  sfl_pkg::rec_t  head;
  logic           accept;
  logic           nul_in;

  assign accept = in_valid && in_ready;
  assign nul_in = accept && (text_byte == sfl_pkg::CH_NUL);

  sfl_step u_step (
    .c         (text_byte),
    .mode      (mode),
    .real_seen (real_seen),
    .mode_next (mode_next),
    .real_next (real_next),
    .stp       (stp)
  );

  sfl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .stp       (stp),
    .pop_ready (out_ready),
    .room      (in_ready),
    .nonempty  (out_valid),
    .head      (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= sfl_pkg::M_IDLE;
      real_seen <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      real_seen <= real_next;
    end
  end

  assign token_byte = head.data;
  assign byte_valid = head.valid;
  assign token_end  = head.tend;
  assign token_type = head.ttype;
  assign last       = head.last;

  `SFL_ASSERT(a_nul_idle, nul_in |=> mode == sfl_pkg::M_IDLE, "mode not idle after end of text")
  `SFL_ASSERT(a_nul_records, nul_in |-> stp.n != 2'd0, "end of text gave no record")

endmodule
